### hdl/dnsx_pkg.sv
// shared types and constants for the dns answer address extractor
`timescale 1ns / 1ps
`default_nettype none
package dnsx_pkg;

  typedef enum logic [7:0] {
    PH_HEADER = 8'b0000_0001,
    PH_QNAME  = 8'b0000_0010,
    PH_QSKIP  = 8'b0000_0100,
    PH_RNAME  = 8'b0000_1000,
    PH_RLABEL = 8'b0001_0000,
    PH_RFIXED = 8'b0010_0000,
    PH_RDATA  = 8'b0100_0000,
    PH_DONE   = 8'b1000_0000
  } phase_t;

  typedef logic [1:0] status_t;

  localparam status_t ST_FOUND  = 2'd0;
  localparam status_t ST_NO_A   = 2'd1;
  localparam status_t ST_SHORT  = 2'd2;
  localparam status_t ST_NO_ANS = 2'd3;

  localparam logic [15:0] QUERY_ID_RESET = 16'h1234;
  localparam logic [7:0]  PTR_MASK       = 8'hC0;
  localparam logic [15:0] TYPE_A         = 16'd1;
  localparam logic [15:0] A_LEN          = 16'd4;

  // header byte positions
  localparam int unsigned HDR_ID_HI  = 0;
  localparam int unsigned HDR_ID_LO  = 1;
  localparam int unsigned HDR_AN_HI  = 6;
  localparam int unsigned HDR_AN_LO  = 7;
  localparam int unsigned HDR_LAST   = 11;

  // question tail after the name, and after a pointer (second pointer byte too)
  localparam logic [15:0] QTAIL_LEN     = 16'd4;
  localparam logic [15:0] QTAIL_PTR_LEN = 16'd5;

  // fixed record fields, by position
  localparam logic [3:0] FIX_PTR_LO  = 4'd0;
  localparam logic [3:0] FIX_TYPE_HI = 4'd1;
  localparam logic [3:0] FIX_TYPE_LO = 4'd2;
  localparam logic [3:0] FIX_LEN_HI  = 4'd9;
  localparam logic [3:0] FIX_LEN_LO  = 4'd10;

endpackage
`default_nettype wire

### hdl/dnsx_ifs.sv
// valid/ready channel interfaces for input bytes, results and configuration
`timescale 1ns / 1ps
`default_nettype none
interface dnsx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] resp_byte;
  logic       last_byte;
  modport source (output valid, output resp_byte, output last_byte, input ready);
  modport sink (input valid, input resp_byte, input last_byte, output ready);
endinterface

interface dnsx_out_if;
  logic                  valid;
  logic                  ready;
  dnsx_pkg::status_t     status;
  logic [31:0]           ipv4_address;
  modport source (output valid, output status, output ipv4_address, input ready);
  modport sink (input valid, input status, input ipv4_address, output ready);
endinterface

interface dnsx_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] query_id;
  modport source (output valid, output query_id, input ready);
  modport sink (input valid, input query_id, output ready);
endinterface
`default_nettype wire

### hdl/dns_answer_address_extractor.sv
// top level: dns response parser reporting the first ipv4 answer address
`timescale 1ns / 1ps
`default_nettype none
// Takes a DNS response one byte per word, with last_byte on the final one, checks the
// header against query_id, skips the question and walks the answer records. The first
// record of type A with a 4-byte payload is reported (status 0) the cycle after its fourth
// data byte; otherwise a failure status follows the final byte. One byte is accepted every
// cycle: each byte is a small update of the parse state, and the only register between the
// two sides is the result register, so input is held off only while a result waits there
// and out ready is low. Bytes beyond MSG_BYTES are not parsed, though a last_byte on them
// still ends the message. query_id is written through the cfg channel, which is always
// ready.
module dns_answer_address_extractor #(
  parameter int unsigned MSG_BYTES = 512
) (
  input  wire            clk,
  input  wire            rst_n,
  dnsx_in_if.sink        in_ch,
  dnsx_out_if.source     out_ch,
  dnsx_cfg_if.sink       cfg_ch
);

  localparam int unsigned PW = $clog2(MSG_BYTES + 1);

  logic [15:0]        query_id_r;
  dnsx_pkg::phase_t   phase_r, phase_nxt;
  logic [PW-1:0]      pos_r, pos_nxt;
  logic [15:0]        skip_r, skip_nxt;
  logic [3:0]         fidx_r, fidx_nxt;
  logic [15:0]        rtype_r, rtype_nxt;
  logic [15:0]        rlen_r, rlen_nxt;
  logic [31:0]        addr_r, addr_nxt;
  logic [1:0]         hflags_r, hflags_nxt;
  logic               reported_r, reported_nxt;

  logic               out_valid_r, out_valid_nxt;
  dnsx_pkg::status_t  out_status_r, out_status_nxt;
  logic [31:0]        out_addr_r, out_addr_nxt;

  logic               in_acc;
  logic               in_rdy;

  assign in_rdy       = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = in_rdy;
  assign in_acc       = in_ch.valid && in_rdy;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.ipv4_address = out_addr_r;

  always_comb begin
    logic [7:0]  b;
    logic        found;
    logic        is_a;
    logic [15:0] len_new;
    logic [15:0] skip_dec;

    b        = in_ch.resp_byte;
    found    = 1'b0;
    is_a     = (rtype_r == dnsx_pkg::TYPE_A) && (rlen_r == dnsx_pkg::A_LEN);
    len_new  = rlen_r;
    skip_dec = skip_r - 16'd1;

    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    skip_nxt     = skip_r;
    fidx_nxt     = fidx_r;
    rtype_nxt    = rtype_r;
    rlen_nxt     = rlen_r;
    addr_nxt     = addr_r;
    hflags_nxt   = hflags_r;
    reported_nxt = reported_r;

    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;

    if (in_acc) begin
      if (pos_r < PW'(MSG_BYTES)) begin
        pos_nxt = pos_r + PW'(1);
        unique case (phase_r)
          dnsx_pkg::PH_HEADER: begin
            if (pos_r == PW'(dnsx_pkg::HDR_ID_HI)) begin
              hflags_nxt = {1'b0, b == query_id_r[15:8]};
            end else if (pos_r == PW'(dnsx_pkg::HDR_ID_LO)) begin
              if (b != query_id_r[7:0]) hflags_nxt[0] = 1'b0;
            end else if (pos_r == PW'(dnsx_pkg::HDR_AN_HI) ||
                         pos_r == PW'(dnsx_pkg::HDR_AN_LO)) begin
              if (b != 8'd0) hflags_nxt[1] = 1'b1;
            end else if (pos_r == PW'(dnsx_pkg::HDR_LAST)) begin
              phase_nxt = (hflags_r == 2'b11) ? dnsx_pkg::PH_QNAME : dnsx_pkg::PH_DONE;
            end
          end
          dnsx_pkg::PH_QNAME: begin
            phase_nxt = dnsx_pkg::PH_QSKIP;
            if (b == 8'd0) begin
              skip_nxt = dnsx_pkg::QTAIL_LEN;
              fidx_nxt = 4'd1;
            end else if ((b & dnsx_pkg::PTR_MASK) == dnsx_pkg::PTR_MASK) begin
              skip_nxt = dnsx_pkg::QTAIL_PTR_LEN;
              fidx_nxt = 4'd1;
            end else begin
              skip_nxt = {8'd0, b};
              fidx_nxt = 4'd0;
            end
          end
          dnsx_pkg::PH_QSKIP: begin
            skip_nxt = skip_dec;
            if (skip_dec == 16'd0) begin
              phase_nxt = (fidx_r != 4'd0) ? dnsx_pkg::PH_RNAME : dnsx_pkg::PH_QNAME;
            end
          end
          dnsx_pkg::PH_RNAME: begin
            if (b == 8'd0) begin
              fidx_nxt  = dnsx_pkg::FIX_TYPE_HI;
              phase_nxt = dnsx_pkg::PH_RFIXED;
            end else if ((b & dnsx_pkg::PTR_MASK) == dnsx_pkg::PTR_MASK) begin
              fidx_nxt  = dnsx_pkg::FIX_PTR_LO;
              phase_nxt = dnsx_pkg::PH_RFIXED;
            end else begin
              skip_nxt  = {8'd0, b};
              phase_nxt = dnsx_pkg::PH_RLABEL;
            end
          end
          dnsx_pkg::PH_RLABEL: begin
            skip_nxt = skip_dec;
            if (skip_dec == 16'd0) phase_nxt = dnsx_pkg::PH_RNAME;
          end
          dnsx_pkg::PH_RFIXED: begin
            case (fidx_r)
              dnsx_pkg::FIX_TYPE_HI: rtype_nxt = {b, 8'd0};
              dnsx_pkg::FIX_TYPE_LO: rtype_nxt = {rtype_r[15:8], b};
              dnsx_pkg::FIX_LEN_HI:  len_new   = {b, 8'd0};
              dnsx_pkg::FIX_LEN_LO:  len_new   = {rlen_r[15:8], b};
              default: ;
            endcase
            rlen_nxt = len_new;
            if (fidx_r >= dnsx_pkg::FIX_LEN_LO) begin
              fidx_nxt = 4'd0;
              if (len_new == 16'd0) begin
                phase_nxt = dnsx_pkg::PH_RNAME;
              end else begin
                skip_nxt  = len_new;
                addr_nxt  = 32'd0;
                phase_nxt = dnsx_pkg::PH_RDATA;
              end
            end else begin
              fidx_nxt = fidx_r + 4'd1;
            end
          end
          dnsx_pkg::PH_RDATA: begin
            if (is_a) addr_nxt = {addr_r[23:0], b};
            skip_nxt = skip_dec;
            if (skip_dec == 16'd0) begin
              if (is_a) begin
                found     = 1'b1;
                phase_nxt = dnsx_pkg::PH_DONE;
              end else begin
                phase_nxt = dnsx_pkg::PH_RNAME;
              end
            end
          end
          dnsx_pkg::PH_DONE: ;
          default: ;
        endcase

        if (found && !reported_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = dnsx_pkg::ST_FOUND;
          out_addr_nxt   = addr_nxt;
          reported_nxt   = 1'b1;
        end
      end

      if (in_ch.last_byte) begin
        if (!reported_nxt) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = 32'd0;
          if (phase_nxt == dnsx_pkg::PH_HEADER || !hflags_nxt[0]) begin
            out_status_nxt = dnsx_pkg::ST_SHORT;
          end else if (!hflags_nxt[1]) begin
            out_status_nxt = dnsx_pkg::ST_NO_ANS;
          end else begin
            out_status_nxt = dnsx_pkg::ST_NO_A;
          end
        end
        phase_nxt    = dnsx_pkg::PH_HEADER;
        pos_nxt      = '0;
        skip_nxt     = 16'd0;
        fidx_nxt     = 4'd0;
        rtype_nxt    = 16'd0;
        rlen_nxt     = 16'd0;
        addr_nxt     = 32'd0;
        hflags_nxt   = 2'b00;
        reported_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_id_r  <= dnsx_pkg::QUERY_ID_RESET;
      phase_r     <= dnsx_pkg::PH_HEADER;
      pos_r       <= '0;
      skip_r      <= 16'd0;
      fidx_r      <= 4'd0;
      rtype_r     <= 16'd0;
      rlen_r      <= 16'd0;
      addr_r      <= 32'd0;
      hflags_r    <= 2'b00;
      reported_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) query_id_r <= cfg_ch.query_id;
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      skip_r      <= skip_nxt;
      fidx_r      <= fidx_nxt;
      rtype_r     <= rtype_nxt;
      rlen_r      <= rlen_nxt;
      addr_r      <= addr_nxt;
      hflags_r    <= hflags_nxt;
      reported_r  <= reported_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result word, no reset needed
  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
  end

endmodule
`default_nettype wire

### hdl/dnsx_checker.sv
// port-level checks for the dns answer address extractor, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module dnsx_checker (
  input wire                     clk,
  input wire                     rst_n,
  input wire                     in_valid,
  input wire                     in_ready,
  input wire                     in_last_byte,
  input wire                     out_valid,
  input wire                     out_ready,
  input wire dnsx_pkg::status_t  out_status,
  input wire [31:0]              out_ipv4_address
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_ipv4_address))
    else $error("result word changed while stalled");

  // input is held off only while a result is waiting
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with free result register");

  // failure reports carry a zero address
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != dnsx_pkg::ST_FOUND |-> out_ipv4_address == 32'd0)
    else $error("address on a failure report");

  // a new failure report follows a final byte
  a_fail_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != dnsx_pkg::ST_FOUND && !$past(out_valid && !out_ready)
    |-> $past(in_valid && in_ready && in_last_byte))
    else $error("failure report without a final byte");

endmodule

bind dns_answer_address_extractor dnsx_checker u_dnsx_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_last_byte     (in_ch.last_byte),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_status       (out_ch.status),
  .out_ipv4_address (out_ch.ipv4_address)
);
`default_nettype wire
